// ----- hdl/kmc_pkg.sv -----
// Shared types and constants for the knapsack min-cost value query unit.
// Used by kmc_merge and knapsack_min_cost_value_query_unit; depends on nothing.
package kmc_pkg;

	// Field widths.
	localparam int COST_W       = 48;
	localparam int ITEM_COST_W  = 30;
	localparam int ITEM_VALUE_W = 9;
	localparam int BEST_W       = 10;

	// Default number of value slots in the table.
	localparam int VALUE_SLOTS_DEF = 1024;

	// Saturated cost that marks an unreachable value.
	localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

	// Largest answer the result port can carry.
	localparam logic [BEST_W-1:0] ANSWER_MAX = {BEST_W{1'b1}};

	// Control that travels with one entry through the sweep pipeline.
	typedef struct packed {
		logic valid;  // entry is in flight
		logic first;  // top entry of a sweep, restarts the running minimum
		logic apply;  // item update applies at this entry
	} kmc_ctl_t;

endpackage

// ----- hdl/kmc_merge.sv -----
// Merge pipeline of the table sweep: saturating min-plus update, then running minimum.
// Depends on kmc_pkg; fed with read data from the table in the top level.
module kmc_merge
	import kmc_pkg::*;
#(
	parameter int AW = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kmc_ctl_t               ctl_s1,
	input  logic [AW-1:0]          addr_s1,
	input  logic [ITEM_COST_W-1:0] cost,
	input  logic [COST_W-1:0]      dst_cost,
	input  logic [COST_W-1:0]      src_cost,
	output logic                   wr_en,
	output logic [AW-1:0]          wr_addr,
	output logic [COST_W-1:0]      wr_data,
	output logic                   busy
);

	kmc_ctl_t            ctl_s2;
	logic [AW-1:0]       addr_s2;
	logic [COST_W-1:0]   upd_s2;
	logic [COST_W-1:0]   run_q;
	logic [COST_W:0]     sum;
	logic [COST_W-1:0]   cand;
	logic [COST_W-1:0]   upd;
	logic [COST_W-1:0]   merged;

	// Candidate cost through the new item, held at infinity once it saturates.
	always_comb begin
		sum  = {1'b0, src_cost} + {{(COST_W + 1 - ITEM_COST_W){1'b0}}, cost};
		cand = (sum >= {1'b0, COST_INF}) ? COST_INF : sum[COST_W-1:0];
		upd  = (ctl_s1.apply && (cand < dst_cost)) ? cand : dst_cost;
	end

	// Stage two control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage two payload.
	always_ff @(posedge clk) begin
		addr_s2 <= addr_s1;
		upd_s2  <= upd;
	end

	// Suffix minimum: each entry takes the least of itself and everything above it.
	always_comb begin
		merged = (ctl_s2.first || (upd_s2 < run_q)) ? upd_s2 : run_q;
	end

	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			run_q <= merged;
		end
	end

	assign wr_en   = ctl_s2.valid;
	assign wr_addr = addr_s2;
	assign wr_data = merged;
	assign busy    = ctl_s2.valid;

`ifndef SYNTHESIS
	// Within one sweep the write address steps down by one entry every beat.
	a_sweep_descends: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && $past(wr_en) && !ctl_s2.first) |-> (wr_addr == $past(wr_addr) - 1'b1))
		else $error("sweep write address did not step down by one");
`endif

endmodule

// ----- hdl/knapsack_min_cost_value_query_unit.sv -----
// Top level of the knapsack min-cost value query unit: table memory, sweep and search control.
// Depends on kmc_pkg and kmc_merge.
//
//  Channel   Handshake          Payload                                  Direction
//  -------   ----------------   --------------------------------------   ---------
//  item      start, busy        mode, item_cost, item_value, budget      in
//  result    done               best_value                               out
//
// After reset the table is cleared one entry per cycle, with busy high.
// An add beat sweeps the table once from the top down, one entry per cycle on the
// two-read one-write table memory: busy stays high until the last entry is written back.
// A query beat runs a binary search, each probe a read state then a compare state for the
// memory read latency: busy stays high until the search ends, and done rises as busy falls.
// The receiver cannot stall; done is high for exactly one cycle per query.
module knapsack_min_cost_value_query_unit
	import kmc_pkg::*;
#(
	parameter int VALUE_SLOTS = VALUE_SLOTS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    mode,
	input  logic [ITEM_COST_W-1:0]  item_cost,
	input  logic [ITEM_VALUE_W-1:0] item_value,
	input  logic [ITEM_COST_W-1:0]  budget,
	output logic                    done,
	output logic [BEST_W-1:0]       best_value
);

	localparam int AW = (VALUE_SLOTS > 1) ? $clog2(VALUE_SLOTS) : 1;
	localparam int CW = ((AW > ITEM_VALUE_W) ? AW : ITEM_VALUE_W) + 1;
	localparam logic [AW-1:0] TOP = AW'(VALUE_SLOTS - 1);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SWEEP = 5'b00100,
		ST_QRD   = 5'b01000,
		ST_QCMP  = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           v_q;
	logic [AW-1:0]           lo_q;
	logic [AW-1:0]           hi_q;
	logic [ITEM_COST_W-1:0]  budget_q;
	logic [ITEM_COST_W-1:0]  item_cost_q;
	logic [ITEM_VALUE_W-1:0] item_value_q;
	logic                    done_q;
	logic [BEST_W-1:0]       best_q;
	kmc_ctl_t                ctl_s1;
	logic [AW-1:0]           addr_s1;

	logic [COST_W-1:0]       table_mem [0:VALUE_SLOTS-1];
	logic [COST_W-1:0]       rd_a_q;
	logic [COST_W-1:0]       rd_b_q;
	logic [AW-1:0]           rd_addr_a;
	logic [AW-1:0]           rd_addr_b;
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [COST_W-1:0]       mem_wdata;

	logic                    m_wr_en;
	logic [AW-1:0]           m_wr_addr;
	logic [COST_W-1:0]       m_wr_data;
	logic                    m_busy;

	logic                    accept;
	logic                    upd_ok;
	logic                    apply_v;
	logic [CW-1:0]           diff;
	logic [AW-1:0]           src_addr;
	logic [AW:0]             mid_sum;
	logic [AW-1:0]           mid;
	logic                    fits;
	logic [AW+BEST_W-1:0]    lo_w;
	logic [BEST_W-1:0]       best_next;

	assign busy   = (state_q != ST_IDLE) || ctl_s1.valid || m_busy;
	assign accept = start && !busy;

	// Item update applies only for a nonzero value that lies inside the table.
	always_comb begin
		upd_ok   = (item_value_q != '0) && (CW'(item_value_q) < CW'(VALUE_SLOTS));
		diff     = CW'(v_q) - CW'(item_value_q);
		apply_v  = upd_ok && (CW'(v_q) >= CW'(item_value_q));
		src_addr = apply_v ? diff[AW-1:0] : v_q;
	end

	// Binary search probe and answer clamp.
	always_comb begin
		mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} + {{AW{1'b0}}, 1'b1};
		mid       = mid_sum[AW:1];
		fits      = rd_b_q <= {{(COST_W - ITEM_COST_W){1'b0}}, budget_q};
		lo_w      = {{BEST_W{1'b0}}, lo_q};
		best_next = (lo_w > (AW + BEST_W)'(ANSWER_MAX)) ? ANSWER_MAX : lo_w[BEST_W-1:0];
	end

	// Memory port selection.
	always_comb begin
		rd_addr_a = v_q;
		rd_addr_b = (state_q == ST_SWEEP) ? src_addr : mid;
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = v_q;
			mem_wdata = (v_q == '0) ? '0 : COST_INF;
		end else begin
			mem_we    = m_wr_en;
			mem_waddr = m_wr_addr;
			mem_wdata = m_wr_data;
		end
	end

	// Table memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= table_mem[rd_addr_a];
		rd_b_q <= table_mem[rd_addr_b];
	end

	// Control sequencer: clear, sweep and search.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			v_q     <= TOP;
			lo_q    <= '0;
			hi_q    <= '0;
			done_q  <= 1'b0;
			ctl_s1  <= '0;
		end else begin
			done_q <= 1'b0;
			ctl_s1 <= '0;
			case (state_q)
				ST_CLEAR: begin
					if (v_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						v_q <= v_q - 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						v_q  <= TOP;
						lo_q <= '0;
						hi_q <= TOP;
						state_q <= mode ? ST_QRD : ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					ctl_s1.valid <= 1'b1;
					ctl_s1.first <= (v_q == TOP);
					ctl_s1.apply <= apply_v;
					if (v_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						v_q <= v_q - 1'b1;
					end
				end
				ST_QRD: begin
					if (lo_q == hi_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_QCMP;
					end
				end
				ST_QCMP: begin
					if (fits) begin
						lo_q <= mid;
					end else begin
						hi_q <= mid - 1'b1;
					end
					state_q <= ST_QRD;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		addr_s1 <= v_q;
		if (accept) begin
			item_cost_q  <= item_cost;
			item_value_q <= item_value;
			budget_q     <= budget;
		end
		if ((state_q == ST_QRD) && (lo_q == hi_q)) begin
			best_q <= best_next;
		end
	end

	assign done       = done_q;
	assign best_value = best_q;

	// Update and running-minimum stages of the sweep.
	kmc_merge #(
		.AW(AW)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.addr_s1  (addr_s1),
		.cost     (item_cost_q),
		.dst_cost (rd_a_q),
		.src_cost (rd_b_q),
		.wr_en    (m_wr_en),
		.wr_addr  (m_wr_addr),
		.wr_data  (m_wr_data),
		.busy     (m_busy)
	);

`ifndef SYNTHESIS
	// A result only follows the final probe of a search.
	a_done_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_QRD))
		else $error("result strobe without a finished search");

	// The sweep has drained before the table is searched.
	a_no_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_QRD) || (state_q == ST_QCMP)) |-> !mem_we)
		else $error("table written during a search");

	// The search window never inverts.
	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_QRD) || (state_q == ST_QCMP)) |-> (lo_q <= hi_q))
		else $error("search window inverted");

	// A new beat is taken only with the sequencer idle and the sweep pipeline empty.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ((state_q == ST_IDLE) && !ctl_s1.valid && !m_wr_en))
		else $error("beat accepted while work was in flight");
`endif

endmodule
